/* src/rc5pd_pkg.sv */
`default_nettype none
package rc5pd_pkg;

  localparam int DUR_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int BIT_LIMIT = 14;
  localparam int CNT_W    = 4;
  localparam int ADDR_W   = 5;
  localparam int CMD_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX  = 8'd3;

  localparam logic [DUR_W-1:0] SHORT_MIN_RST = 16'd711;
  localparam logic [DUR_W-1:0] SHORT_MAX_RST = 16'd1066;
  localparam logic [DUR_W-1:0] LONG_MIN_RST  = 16'd1422;
  localparam logic [DUR_W-1:0] LONG_MAX_RST  = 16'd2132;

  typedef struct packed {
    logic [DUR_W-1:0] short_min;
    logic [DUR_W-1:0] short_max;
    logic [DUR_W-1:0] long_min;
    logic [DUR_W-1:0] long_max;
  } win_cfg_t;

  typedef struct packed {
    logic is_short;
    logic is_long;
  } pulse_class_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [CMD_W-1:0]  command;
    logic              toggle;
  } rc5_result_t;

endpackage
`default_nettype wire

/* src/rc5_pulse_decoder.sv */
`default_nettype none
// A result for the last pulse reaches the out_ ports by way of the input register, then the result register.
// Throughput: one pulse per cycle; input register, then decode and frame state, then result
// register. Only a last pulse stalls: it waits in the input register, holding off the input,
// while the previous result is still untaken.
// Reset: synchronous, active low; clears frame state and valid flags and loads the window
// registers with their default values.
module rc5_pulse_decoder
  import rc5pd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [DUR_W-1:0]     in_pulse_duration,
  input  wire logic                 in_last_pulse,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ADDR_W-1:0]         out_address,
  output logic [CMD_W-1:0]          out_command,
  output logic                      out_toggle
);

  win_cfg_t         win_r, win_nxt;
  logic [DUR_W-1:0] dur_r;
  logic             last_r;
  logic             s1_vld_r, s1_vld_nxt;
  logic             s1_adv;
  logic             out_vld_r, out_vld_nxt;
  rc5_result_t      res_r;
  rc5_result_t      res;
  pulse_class_t     cls;

  assign cfg_ready = 1'b1;

  always_comb begin
    win_nxt = win_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SHORT_MIN: win_nxt.short_min = cfg_data;
        CFG_SHORT_MAX: win_nxt.short_max = cfg_data;
        CFG_LONG_MIN:  win_nxt.long_min  = cfg_data;
        CFG_LONG_MAX:  win_nxt.long_max  = cfg_data;
        default:       win_nxt = win_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.short_min <= SHORT_MIN_RST;
      win_r.short_max <= SHORT_MAX_RST;
      win_r.long_min  <= LONG_MIN_RST;
      win_r.long_max  <= LONG_MAX_RST;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign s1_adv   = s1_vld_r && (!last_r || !out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  assign s1_vld_nxt = (in_valid && in_ready) || (s1_vld_r && !s1_adv);

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ready;
    if (s1_adv && last_r) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dur_r  <= in_pulse_duration;
      last_r <= in_last_pulse;
    end
    if (s1_adv && last_r) begin
      res_r <= res;
    end
  end

  rc5pd_classify u_classify (
    .win (win_r),
    .dur (dur_r),
    .cls (cls)
  );

  rc5pd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .last  (last_r),
    .cls   (cls),
    .res   (res)
  );

  assign out_valid   = out_vld_r;
  assign out_address = res_r.address;
  assign out_command = res_r.command;
  assign out_toggle  = res_r.toggle;

endmodule
`default_nettype wire

/* src/rc5pd_classify.sv */
`default_nettype none
module rc5pd_classify
  import rc5pd_pkg::*;
(
  input  wire win_cfg_t          win,
  input  wire logic [DUR_W-1:0]  dur,
  output pulse_class_t           cls
);

  logic in_short;
  logic in_long;

  assign in_short = (dur >= win.short_min) && (dur <= win.short_max);
  assign in_long  = (dur >= win.long_min) && (dur <= win.long_max);

  // short window wins where both match
  assign cls.is_short = in_short;
  assign cls.is_long  = in_long && !in_short;

endmodule
`default_nettype wire

/* src/rc5pd_core.sv */
`default_nettype none
module rc5pd_core
  import rc5pd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic         last,
  input  wire pulse_class_t cls,
  output rc5_result_t       res
);

  logic [BIT_LIMIT-1:0] store_r, store_nxt, store_upd;
  logic [CNT_W-1:0]     count_r, count_nxt, count_upd;
  logic                 level_r, level_nxt, level_upd;
  logic                 pend_r, pend_nxt, pend_upd;
  logic                 abort_r, abort_nxt, abort_upd;
  logic                 push;
  logic [CNT_W-1:0]     bit_idx;

  assign bit_idx = CNT_W'(BIT_LIMIT - 1) - count_r;

  always_comb begin
    level_upd = level_r;
    pend_upd  = pend_r;
    abort_upd = abort_r;
    push      = 1'b0;
    if (!abort_r) begin
      if (cls.is_short) begin
        if (pend_r) begin
          pend_upd = 1'b0;
          push     = 1'b1;
        end else begin
          pend_upd = 1'b1;
        end
      end else if (cls.is_long) begin
        if (pend_r) begin
          abort_upd = 1'b1;
        end else begin
          level_upd = !level_r;
          push      = 1'b1;
        end
      end else begin
        abort_upd = 1'b1;
      end
    end
  end

  always_comb begin
    store_upd = store_r;
    count_upd = count_r;
    if (push && (count_r < CNT_W'(BIT_LIMIT))) begin
      store_upd = store_r | (BIT_LIMIT'(level_upd) << bit_idx);
      count_upd = count_r + CNT_W'(1);
    end
  end

  // result fields taken after this pulse is applied
  assign res.address = store_upd[11:7];
  assign res.toggle  = store_upd[12];
  assign res.command = store_upd[6:1];

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    level_nxt = level_r;
    pend_nxt  = pend_r;
    abort_nxt = abort_r;
    if (step) begin
      if (last) begin
        store_nxt = '0;
        count_nxt = '0;
        level_nxt = 1'b1;
        pend_nxt  = 1'b0;
        abort_nxt = 1'b0;
      end else begin
        store_nxt = store_upd;
        count_nxt = count_upd;
        level_nxt = level_upd;
        pend_nxt  = pend_upd;
        abort_nxt = abort_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      count_r <= '0;
      level_r <= 1'b1;
      pend_r  <= 1'b0;
      abort_r <= 1'b0;
    end else begin
      store_r <= store_nxt;
      count_r <= count_nxt;
      level_r <= level_nxt;
      pend_r  <= pend_nxt;
      abort_r <= abort_nxt;
    end
  end

endmodule
`default_nettype wire
